>>> hw/rtl/pacn_pkg.sv
// Shared types and constants of the path attribute set canonicalizer.
package pacn_pkg;

   localparam int MaxAttrs = 32;
   localparam int IdxW = $clog2(MaxAttrs);
   localparam int CntW = $clog2(MaxAttrs + 1);
   localparam int OffW = 22;

   localparam logic [7:0] LongLenLimit = 8'd255;
   localparam logic [OffW-1:0] BaseHdrBytes = 22'd3;

   localparam logic [3:0] ClsOptTrans = 4'b0001;
   localparam logic [3:0] ClsOptNonTrans = 4'b0010;
   localparam logic [3:0] ClsWellKnown = 4'b0100;
   localparam logic [3:0] ClsDuplicate = 4'b1000;

   typedef struct packed {
      logic [7:0]      flags;
      logic [7:0]      atype;
      logic [15:0]     length;
      logic [IdxW-1:0] src;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic emit;
      logic first;
      logic final_step;
      logic [IdxW-1:0] step;
   } cmd_type;

endpackage

>>> hw/rtl/path_attribute_set_canonicalizer.sv
// Top level: configuration register, controller and datapath.
//
// Headers load one per cycle while busy is low; each that fits is inserted in type order
// into a 32-entry register row as it arrives. The item marked last then starts two passes
// over the row, each rotating all 32 entries once: a scan pass that classifies the set
// and totals the stash, and an emit pass that drives one result per kept header, or a
// single empty-set result when none is kept. Busy stays high through both passes;
// results come at most one per cycle during the emit pass, with gaps where headers are
// dropped, the final one possibly appearing only once busy has fallen, and they cannot
// be stalled.
module path_attribute_set_canonicalizer import pacn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_attr_flags,
   input  logic [7:0]  req_attr_type,
   input  logic [15:0] req_attr_length,
   input  logic        req_set_last,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_flags,
   output logic [7:0]  rsp_out_type,
   output logic [15:0] rsp_out_length,
   output logic [4:0]  rsp_source_index,
   output logic [21:0] rsp_stash_offset,
   output logic [21:0] rsp_stash_total,
   output logic [3:0]  rsp_set_class,
   output logic        rsp_set_empty,
   output logic        rsp_overflowed,
   output logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cmd_type cmd;
   logic    filter_ff, filter_in;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'd0, filter_ff} : 32'd0;

   always_comb begin
      filter_in = filter_ff;
      if (psel && penable && pwrite && paddr[2] == 1'b0) filter_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) filter_ff <= 1'b1;
      else filter_ff <= filter_in;
   end

   pacn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .set_last (req_set_last),
      .busy     (busy),
      .cmd      (cmd)
   );

   pacn_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .filter           (filter_ff),
      .in_flags         (req_attr_flags),
      .in_type          (req_attr_type),
      .in_length        (req_attr_length),
      .rsp_valid        (rsp_valid),
      .rsp_out_flags    (rsp_out_flags),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_length   (rsp_out_length),
      .rsp_source_index (rsp_source_index),
      .rsp_stash_offset (rsp_stash_offset),
      .rsp_stash_total  (rsp_stash_total),
      .rsp_set_class    (rsp_set_class),
      .rsp_set_empty    (rsp_set_empty),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

>>> hw/rtl/pacn_ctrl.sv
// Controller state machine: load, scan pass and emit pass sequencing.
module pacn_ctrl import pacn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    set_last,
   output logic    busy,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE = 3'b001,
      SCAN = 3'b010,
      EMIT = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] step_ff, step_in;
   logic            at_end;

   assign at_end = (step_ff == IdxW'(MaxAttrs - 1));
   assign busy = (state_ff != IDLE);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      cmd.step = step_ff;
      cmd.first = (step_ff == '0);
      cmd.final_step = at_end;
      unique case (state_ff)
         IDLE: begin
            step_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               if (set_last) state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan = 1'b1;
            step_in = step_ff + 1'b1;
            if (at_end) state_in = EMIT;
         end
         EMIT: begin
            cmd.emit = 1'b1;
            step_in = step_ff + 1'b1;
            if (at_end) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

endmodule

>>> hw/rtl/pacn_datapath.sv
// Datapath: sorted header row, classification and canonical result registers.
module pacn_datapath import pacn_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  logic            filter,
   input  logic [7:0]      in_flags,
   input  logic [7:0]      in_type,
   input  logic [15:0]     in_length,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_flags,
   output logic [7:0]      rsp_out_type,
   output logic [15:0]     rsp_out_length,
   output logic [4:0]      rsp_source_index,
   output logic [OffW-1:0] rsp_stash_offset,
   output logic [OffW-1:0] rsp_stash_total,
   output logic [3:0]      rsp_set_class,
   output logic            rsp_set_empty,
   output logic            rsp_overflowed,
   output logic            rsp_last_out
);

   entry_type       row_ff [MaxAttrs];
   entry_type       row_in [MaxAttrs];
   logic            le     [MaxAttrs];
   logic [CntW-1:0] count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic [7:0]      prev_ff;
   logic [3:0]      cls_ff, cls_in;
   logic [CntW-1:0] nk_ff, nk_in;
   logic [OffW-1:0] total_ff, total_in;
   logic [OffW-1:0] off_ff, off_in;
   logic [CntW-1:0] sent_ff, sent_in;

   logic            valid_ff, valid_in;
   logic [7:0]      oflags_ff, oflags_in, otype_ff, otype_in;
   logic [15:0]     olen_ff, olen_in;
   logic [4:0]      osrc_ff, osrc_in;
   logic [OffW-1:0] ooff_ff, ooff_in, otot_ff, otot_in;
   logic [3:0]      ocls_ff, ocls_in;
   logic            oempty_ff, oempty_in, oovf_ff, oovf_in, olast_ff, olast_in;

   entry_type       cur, nxt;
   logic            active, has_next, dup, keep, ext, room, is_last;
   logic [OffW-1:0] hsize;
   logic [3:0]      kind;

   assign room = (count_ff < CntW'(MaxAttrs));

   // Stable insertion: a new header goes after every stored one of equal or lower type.
   always_comb begin
      for (int i = 0; i < MaxAttrs; i++) begin
         le[i] = (CntW'(i) < count_ff) && (row_ff[i].atype <= in_type);
      end
      for (int i = 0; i < MaxAttrs; i++) begin
         row_in[i] = row_ff[i];
         if (cmd.load && room) begin
            if (!le[i] && (i == 0 || le[(i == 0) ? 0 : i - 1])) begin
               row_in[i].flags = in_flags;
               row_in[i].atype = in_type;
               row_in[i].length = in_length;
               row_in[i].src = count_ff[IdxW-1:0];
            end else if (!le[i] && i > 0) begin
               row_in[i] = row_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.scan || cmd.emit) begin
            row_in[i] = row_ff[(i + 1) % MaxAttrs];
         end
      end
   end

   assign cur = row_ff[0];
   assign nxt = row_ff[1 % MaxAttrs];
   assign active = ({1'b0, cmd.step} < count_ff);
   assign has_next = (CntW'(cmd.step) + 1'b1 < count_ff);
   assign dup = (!cmd.first && prev_ff == cur.atype) || (has_next && nxt.atype == cur.atype);
   assign keep = !filter || (!dup && cur.flags[7] && cur.flags[6]);
   assign ext = (cur.length > {8'd0, LongLenLimit});
   assign hsize = BaseHdrBytes + OffW'(ext) + OffW'(cur.length);
   assign is_last = ((cmd.first ? '0 : sent_ff) + 1'b1 == nk_ff);

   always_comb begin
      if (!cur.flags[7]) kind = ClsWellKnown;
      else if (cur.flags[6]) kind = ClsOptTrans;
      else kind = ClsOptNonTrans;
   end

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      cls_in = cls_ff;
      nk_in = nk_ff;
      total_in = total_ff;
      off_in = off_ff;
      sent_in = sent_ff;
      valid_in = 1'b0;
      oflags_in = oflags_ff;
      otype_in = otype_ff;
      olen_in = olen_ff;
      osrc_in = osrc_ff;
      ooff_in = ooff_ff;
      otot_in = otot_ff;
      ocls_in = ocls_ff;
      oempty_in = oempty_ff;
      oovf_in = oovf_ff;
      olast_in = olast_ff;
      if (cmd.load) begin
         if (room) count_in = count_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (cmd.scan) begin
         if (cmd.first) begin
            cls_in = '0;
            nk_in = '0;
            total_in = '0;
         end
         if (active) begin
            cls_in = cls_in | kind |
                     ((!cmd.first && prev_ff == cur.atype) ? ClsDuplicate : 4'd0);
            if (keep) begin
               nk_in = nk_in + 1'b1;
               total_in = total_in + hsize;
            end
         end
      end
      if (cmd.emit) begin
         if (cmd.first) begin
            off_in = '0;
            sent_in = '0;
         end
         if (cmd.first && nk_ff == '0) begin
            valid_in = 1'b1;
            oflags_in = '0;
            otype_in = '0;
            olen_in = '0;
            osrc_in = '0;
            ooff_in = '0;
            otot_in = '0;
            ocls_in = '0;
            oempty_in = 1'b1;
            oovf_in = ovf_ff;
            olast_in = 1'b1;
         end else if (active && keep) begin
            valid_in = 1'b1;
            oflags_in = {cur.flags[7:6], cur.flags[5] | filter, ext, 4'd0};
            otype_in = cur.atype;
            olen_in = cur.length;
            osrc_in = 5'(cur.src);
            ooff_in = off_in;
            otot_in = is_last ? total_ff : '0;
            ocls_in = filter ? ClsOptTrans : cls_ff;
            oempty_in = 1'b0;
            oovf_in = ovf_ff;
            olast_in = is_last;
            off_in = off_in + hsize;
            sent_in = sent_in + 1'b1;
         end
         if (cmd.final_step) begin
            count_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxAttrs; i++) row_ff[i] <= row_in[i];
      if (cmd.scan || cmd.emit) prev_ff <= cur.atype;
      cls_ff <= cls_in;
      nk_ff <= nk_in;
      total_ff <= total_in;
      off_ff <= off_in;
      sent_ff <= sent_in;
      oflags_ff <= oflags_in;
      otype_ff <= otype_in;
      olen_ff <= olen_in;
      osrc_ff <= osrc_in;
      ooff_ff <= ooff_in;
      otot_ff <= otot_in;
      ocls_ff <= ocls_in;
      oempty_ff <= oempty_in;
      oovf_ff <= oovf_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_flags = oflags_ff;
   assign rsp_out_type = otype_ff;
   assign rsp_out_length = olen_ff;
   assign rsp_source_index = osrc_ff;
   assign rsp_stash_offset = ooff_ff;
   assign rsp_stash_total = otot_ff;
   assign rsp_set_class = ocls_ff;
   assign rsp_set_empty = oempty_ff;
   assign rsp_overflowed = oovf_ff;
   assign rsp_last_out = olast_ff;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the path attribute set canonicalizer: random and directed sets checked against a predictor.
module tb_top;
   import pacn_pkg::*;

   typedef struct {
      logic [7:0]  flags;
      logic [7:0]  atype;
      logic [15:0] length;
      logic        last;
   } hdr_item;

   typedef struct {
      logic [7:0]  flags;
      logic [7:0]  atype;
      logic [15:0] length;
      logic [4:0]  src;
      logic [21:0] offset;
      logic [21:0] total;
      logic [3:0]  cls;
      logic        empty;
      logic        ovf;
      logic        last;
   } canon_hdr;

   localparam logic [2:0] AddrFilter = 3'd0;
   localparam logic [7:0] FlOpt = 8'h80, FlTrans = 8'h40, FlPartial = 8'h20;
   localparam logic [7:0] FlExt = 8'h10;
   localparam int CycleLimit = 400000;

   logic clock = 0, reset = 1, start = 0, busy;
   logic [7:0] req_attr_flags = 0, req_attr_type = 0;
   logic [15:0] req_attr_length = 0;
   logic req_set_last = 0;
   logic rsp_valid;
   logic [7:0] rsp_out_flags, rsp_out_type;
   logic [15:0] rsp_out_length;
   logic [4:0] rsp_source_index;
   logic [21:0] rsp_stash_offset, rsp_stash_total;
   logic [3:0] rsp_set_class;
   logic rsp_set_empty, rsp_overflowed, rsp_last_out;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   path_attribute_set_canonicalizer dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   hdr_item pending_hdrs[$];
   canon_hdr expected_hdrs[$];
   hdr_item set_row[$];
   logic overflow_seen = 0;
   logic filter_on = 1;
   int errors = 0;
   int cycles = 0;
   bit quiet_stretch = 0;
   logic busy_at_edge;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Mirrors the block for one accepted header; may queue a whole set of results.
   task automatic canonicalize(input hdr_item h);
      hdr_item srt[$];
      int ord[$];
      int keepi[$];
      logic [3:0] cls;
      logic [21:0] off, tot;
      int n, j, v;
      bit dup;
      canon_hdr r;
      if (set_row.size() < MaxAttrs) set_row.push_back(h);
      else overflow_seen = 1;
      if (!h.last) return;
      n = set_row.size();
      for (int i = 0; i < n; i++) begin
         v = i;
         j = ord.size();
         ord.push_back(0);
         while (j > 0 && set_row[ord[j-1]].atype > set_row[v].atype) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = v;
      end
      cls = 0;
      for (int i = 0; i < n; i++) begin
         if (set_row[ord[i]].flags & FlOpt)
            cls |= (set_row[ord[i]].flags & FlTrans) ? ClsOptTrans : ClsOptNonTrans;
         else cls |= ClsWellKnown;
         if (i != 0 && set_row[ord[i]].atype == set_row[ord[i-1]].atype) cls |= ClsDuplicate;
      end
      if (filter_on) begin
         if (cls & ClsOptTrans)
            for (int i = 0; i < n; i++) begin
               dup = (i > 0 && set_row[ord[i-1]].atype == set_row[ord[i]].atype) ||
                     (i + 1 < n && set_row[ord[i+1]].atype == set_row[ord[i]].atype);
               if (!dup && (set_row[ord[i]].flags & (FlOpt | FlTrans)) == (FlOpt | FlTrans))
                  keepi.push_back(ord[i]);
            end
      end else keepi = ord;
      r = '{default: 0};
      r.ovf = overflow_seen;
      if (keepi.size() == 0) begin
         r.empty = 1;
         r.last = 1;
         expected_hdrs.push_back(r);
      end else begin
         if (filter_on) cls = ClsOptTrans;
         tot = 0;
         foreach (keepi[k])
            tot += 22'd3 + (set_row[keepi[k]].length > 255) + set_row[keepi[k]].length;
         off = 0;
         foreach (keepi[k]) begin
            r.length = set_row[keepi[k]].length;
            r.flags = set_row[keepi[k]].flags & 8'hE0;
            if (r.length > 255) r.flags |= FlExt;
            if (filter_on) r.flags |= FlPartial;
            r.atype = set_row[keepi[k]].atype;
            r.src = 5'(keepi[k]);
            r.offset = off;
            r.last = (k == keepi.size() - 1);
            r.total = r.last ? tot : 0;
            r.cls = cls;
            expected_hdrs.push_back(r);
            off += 22'd3 + (r.length > 255) + r.length;
         end
      end
      set_row.delete();
      overflow_seen = 0;
   endtask

   // Driver: presents queued headers, idling about a third of the cycles unless quiet_stretch is set.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy_at_edge) begin
            void'(pending_hdrs.pop_front());
         end
         if (pending_hdrs.size() > 0 && (quiet_stretch || $urandom_range(99) >= 33)) begin
            start <= 1;
            req_attr_flags <= pending_hdrs[0].flags;
            req_attr_type <= pending_hdrs[0].atype;
            req_attr_length <= pending_hdrs[0].length;
            req_set_last <= pending_hdrs[0].last;
         end else start <= 0;
      end
   end

   always @(posedge clock) begin
      busy_at_edge <= busy;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Monitor: model accepted headers and check every strobed result.
   always @(posedge clock) begin
      canon_hdr e;
      if (!reset && start && !busy)
         canonicalize('{req_attr_flags, req_attr_type, req_attr_length, req_set_last});
      if (!reset && rsp_valid) begin
         if (expected_hdrs.size() == 0) report_mismatch("unexpected result", 0, 0);
         else begin
            e = expected_hdrs.pop_front();
            if (rsp_out_flags !== e.flags) report_mismatch("flags", rsp_out_flags, e.flags);
            if (rsp_out_type !== e.atype) report_mismatch("type", rsp_out_type, e.atype);
            if (rsp_out_length !== e.length) report_mismatch("length", rsp_out_length, e.length);
            if (rsp_source_index !== e.src) report_mismatch("source", rsp_source_index, e.src);
            if (rsp_stash_offset !== e.offset)
               report_mismatch("offset", rsp_stash_offset, e.offset);
            if (rsp_stash_total !== e.total) report_mismatch("total", rsp_stash_total, e.total);
            if (rsp_set_class !== e.cls) report_mismatch("class", rsp_set_class, e.cls);
            if (rsp_set_empty !== e.empty) report_mismatch("empty", rsp_set_empty, e.empty);
            if (rsp_overflowed !== e.ovf) report_mismatch("overflow", rsp_overflowed, e.ovf);
            if (rsp_last_out !== e.last) report_mismatch("last", rsp_last_out, e.last);
         end
      end
   end

   task automatic write_filter(input logic value);
      @(negedge clock);
      psel <= 1;
      pwrite <= 1;
      paddr <= AddrFilter;
      pwdata <= {31'd0, value};
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      filter_on = value;
   endtask

   task automatic queue_hdr(input logic [7:0] f, input logic [7:0] t,
                            input logic [15:0] l, input logic last);
      pending_hdrs.push_back('{f, t, l, last});
   endtask

   // Mostly well-formed sets, with small type ranges half of the time so duplicates occur.
   task automatic queue_random_set(input int n);
      int tspan;
      tspan = $urandom_range(1) ? 8 : 255;
      for (int i = 0; i < n; i++)
         queue_hdr($urandom_range(3) != 0 ? {2'b11, 6'($urandom)} : 8'($urandom),
                   8'($urandom_range(tspan)),
                   $urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(300)),
                   i == n - 1);
   endtask

   task automatic drain();
      while (pending_hdrs.size() > 0 || start || busy || expected_hdrs.size() > 0)
         @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   int sent;
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Filter on (reset value): unique opt-trans kept, duplicates and others dropped.
      queue_hdr(8'hFF, 8'd5, 16'd256, 0);
      queue_hdr(8'hC0, 8'd5, 16'd1, 0);
      queue_hdr(8'hCF, 8'd0, 16'd255, 0);
      queue_hdr(8'h80, 8'd9, 16'd3, 0);
      queue_hdr(8'h40, 8'd2, 16'd0, 0);
      queue_hdr(8'hE0, 8'd255, 16'hFFFF, 1);
      queue_hdr(8'h80, 8'd1, 16'd0, 1);
      drain();
      write_filter(0);
      queue_hdr(8'h00, 8'd7, 16'd0, 1);
      for (int i = 0; i < 34; i++)
         queue_hdr(8'($urandom), 8'($urandom_range(3)), 16'hFFFF, i == 33);
      queue_hdr(8'h3F, 8'd200, 16'd256, 0);
      queue_hdr(8'hA0, 8'd200, 16'd10, 1);
      drain();
      sent = 50;
      for (int ph = 0; ph < 4; ph++) begin
         quiet_stretch = (ph == 2);
         write_filter(ph[0]);
         while (sent < 50 + 75 * (ph + 1)) begin
            int n;
            n = $urandom_range(9) == 0 ? $urandom_range(33, 36) : $urandom_range(1, 6);
            queue_random_set(n);
            sent += n;
         end
         drain();
      end
      write_filter(1);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
